// File: sv/hafs_pkg.sv
// Shared types and constants for the handle allocator with free stack.
`timescale 1ns / 1ps

package hafs_pkg;

    localparam int ENTRIES   = 256;
    localparam int REF_WIDTH = 48;
    localparam int ID_W      = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]           command;
        logic [ID_W-1:0]      handle_id;
        logic [REF_WIDTH-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]      result_id;
        logic [REF_WIDTH-1:0] result_value;
        logic [1:0]           status;
    } rsp_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

// File: sv/hafs_ctrl.sv
// Controller state machine: accepts a request, then runs the execute state.
`timescale 1ns / 1ps

module hafs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output hafs_pkg::ctl_t ctl
);
    import hafs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        busy       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy       = 1'b1;
                ctl.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/hafs_datapath.sv
// Datapath: entry memory, free stack memory, counters and result register.
`timescale 1ns / 1ps

module hafs_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  hafs_pkg::ctl_t ctl,
    input  hafs_pkg::req_t request,
    output logic           done,
    output hafs_pkg::rsp_t result
);
    import hafs_pkg::*;

    logic [REF_WIDTH-1:0] entry_mem [ENTRIES];
    logic [IDX_W-1:0]     stack_mem [ENTRIES];

    req_t                 req_reg;
    logic [REF_WIDTH-1:0] entry_rd_reg;
    logic [IDX_W-1:0]     stack_rd_reg;
    logic [CNT_W-1:0]     used_count_reg;
    logic [CNT_W-1:0]     used_count_next;
    logic [CNT_W-1:0]     free_count_reg;
    logic [CNT_W-1:0]     free_count_next;
    rsp_t                 result_reg;
    rsp_t                 result_next;
    logic                 done_reg;

    logic [IDX_W-1:0]     stack_raddr;
    logic                 entry_we;
    logic [IDX_W-1:0]     entry_waddr;
    logic [REF_WIDTH-1:0] entry_wdata;
    logic                 stack_we;
    logic [IDX_W-1:0]     stack_waddr;
    logic                 id_valid;

    // Top of stack sits one below the fill count
    assign stack_raddr = IDX_W'(free_count_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        if (ctl.load)
        begin
            entry_rd_reg <= entry_mem[IDX_W'(request.handle_id)];
            req_reg      <= request;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= IDX_W'(req_reg.handle_id);
        end
        if (ctl.load)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    assign id_valid = (CNT_W'(req_reg.handle_id) < used_count_reg) && (entry_rd_reg != '0);

    always_comb
    begin
        used_count_next          = used_count_reg;
        free_count_next          = free_count_reg;
        entry_we                 = 1'b0;
        entry_waddr              = IDX_W'(req_reg.handle_id);
        entry_wdata              = '0;
        stack_we                 = 1'b0;
        stack_waddr              = IDX_W'(free_count_reg);
        result_next.result_id    = req_reg.handle_id;
        result_next.result_value = '0;
        result_next.status       = ST_INVALID;
        if (ctl.exec)
        begin
            unique case (req_reg.command)
                CMD_CREATE:
                begin
                    entry_wdata = req_reg.entry_value;
                    priority if (free_count_reg != '0)
                    begin
                        // Reuse the most recently freed id
                        free_count_next       = free_count_reg - CNT_W'(1);
                        entry_we              = 1'b1;
                        entry_waddr           = stack_rd_reg;
                        result_next.result_id = ID_W'(stack_rd_reg);
                        result_next.status    = ST_OK;
                    end
                    else if (used_count_reg != CNT_W'(ENTRIES))
                    begin
                        used_count_next       = used_count_reg + CNT_W'(1);
                        entry_we              = 1'b1;
                        entry_waddr           = IDX_W'(used_count_reg);
                        result_next.result_id = ID_W'(used_count_reg);
                        result_next.status    = ST_OK;
                    end
                    else
                    begin
                        result_next.status = ST_FULL;
                    end
                end
                CMD_DELETE:
                begin
                    if (id_valid && (free_count_reg != CNT_W'(ENTRIES)))
                    begin
                        entry_we           = 1'b1;
                        stack_we           = 1'b1;
                        free_count_next    = free_count_reg + CNT_W'(1);
                        result_next.status = ST_OK;
                    end
                end
                CMD_GET:
                begin
                    if (id_valid)
                    begin
                        result_next.result_value = entry_rd_reg;
                        result_next.status       = ST_OK;
                    end
                end
                default:
                begin
                    result_next.status = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            free_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_count_reg <= used_count_next;
            free_count_reg <= free_count_next;
            done_reg       <= ctl.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/handle_allocator_free_stack.sv
// Top level of the handle allocator with a LIFO free stack.
//
// Usage: present a request (command, handle_id, entry_value) with start high.
// The request is taken at a rising edge where start is high and busy is low.
// Create allocates an id (last freed first, else the next unused one) and
// stores the reference; delete clears a live entry and stacks its id; get
// returns the reference held by a live id. A zero reference marks an empty
// entry.
// Each request reads the entry memory and the free stack in its accept cycle
// and writes them back in the following execute cycle, during which busy is
// high. The result is registered at the end of the execute cycle and appears
// with done high for exactly one cycle; a new request can be taken in that
// same cycle, once the previous request has executed. The receiver cannot stall:
// done is a one-cycle strobe and must be sampled when it occurs.
// Reset clears the used and free counts and the controller; memory contents
// are left as they are; unwritten locations may be read but are never used.
`timescale 1ns / 1ps

module handle_allocator_free_stack (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  hafs_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output hafs_pkg::rsp_t result
);
    import hafs_pkg::*;

    ctl_t ctl;

    hafs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    hafs_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .done    (done),
        .result  (result)
    );

endmodule
